/* sv/hook_vertex_deform_falloff_core_assert.svh */
// Assertion macros shared by the hook vertex deform falloff RTL
`ifndef HOOK_VERTEX_DEFORM_FALLOFF_CORE_ASSERT_SVH
`define HOOK_VERTEX_DEFORM_FALLOFF_CORE_ASSERT_SVH

// Same-cycle implication, checked on clk, quiet while rst is high
`define HVD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hvd assertion failed");

// Next-cycle implication, checked on clk, quiet while rst is high
`define HVD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hvd assertion failed");

`endif

/* sv/hvd_pkg.sv */
// Types, constants and arithmetic helpers of the hook vertex deformer
`timescale 1ns / 1ps
package hvd_pkg;

  localparam int COEF_DEPTH   = 21;
  localparam int UNI_BASE     = 12;
  localparam int FRONT_STAGES = 5;
  localparam int FALL_STAGES  = 14;
  localparam int BLEND_STAGES = 2;
  localparam int STAGES       = FRONT_STAGES + FALL_STAGES + BLEND_STAGES;

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_DEFORM = 1'b1;

  localparam logic [2:0] KIND_NONE     = 3'd0;
  localparam logic [2:0] KIND_CONSTANT = 3'd1;
  localparam logic [2:0] KIND_INVSQ    = 3'd2;
  localparam logic [2:0] KIND_LINEAR   = 3'd3;
  localparam logic [2:0] KIND_SHARP    = 3'd4;
  localparam logic [2:0] KIND_SMOOTH   = 3'd5;
  localparam logic [2:0] KIND_ROOT     = 3'd6;
  localparam logic [2:0] KIND_SPHERE   = 3'd7;

  localparam logic [2:0] REG_KIND     = 3'd0;
  localparam logic [2:0] REG_RADIUS   = 3'd1;
  localparam logic [2:0] REG_STRENGTH = 3'd2;
  localparam logic [2:0] REG_FLAGS    = 3'd3;
  localparam logic [2:0] REG_CX       = 3'd4;
  localparam logic [2:0] REG_CY       = 3'd5;
  localparam logic [2:0] REG_CZ       = 3'd6;

  localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

  typedef struct packed {
    logic               opcode;
    logic [4:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
    logic               has_weight;
    logic [16:0]        vertex_weight;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
  } out_t;

  typedef struct packed {
    logic [2:0]         falloff_kind;
    logic [30:0]        hook_radius;
    logic [16:0]        strength;
    logic [1:0]         mode_flags;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
  } cfg_t;

  typedef enum logic [1:0] {FAC_STRENGTH, FAC_ZERO, FAC_CURVE} fac_sel_t;

  // Per-vertex data that rides along the front and falloff stages
  typedef struct packed {
    logic [2:0][31:0] co;
    logic [2:0][31:0] img;
    logic [16:0]      w;
    logic             has_w;
  } carry_t;

  typedef struct packed {
    logic [63:0] x;
    logic [33:0] rem;
    logic [31:0] root;
  } sq_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [16:0] q;
  } dv_t;

  function automatic logic signed [63:0] mul_s32(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return 64'(a) * 64'(b);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > SAT_MAX) return 32'sh7FFFFFFF;
    if (v < SAT_MIN) return 32'sh80000000;
    return 32'(v);
  endfunction

  // One digit of the square root: bring down two bits, try root*4+1
  function automatic sq_t sqrt_step(input sq_t s);
    logic [34:0] r2;
    logic [34:0] trial;
    sq_t         n;
    r2    = {s.rem[32:0], s.x[63:62]};
    trial = 35'({s.root, 2'b01});
    n.x   = {s.x[61:0], 2'b00};
    if (r2 >= trial) begin
      n.rem  = 34'(r2 - trial);
      n.root = {s.root[30:0], 1'b1};
    end else begin
      n.rem  = 34'(r2);
      n.root = {s.root[30:0], 1'b0};
    end
    return n;
  endfunction

  function automatic sq_t sqrt_steps(input sq_t s, input int unsigned n);
    sq_t t;
    t = s;
    for (int i = 0; i < 8; i++) begin
      if (i < n) t = sqrt_step(t);
    end
    return t;
  endfunction

  // Restoring division steps, one quotient bit each
  function automatic dv_t div_steps(input dv_t s, input logic [63:0] den);
    dv_t t;
    t = s;
    for (int i = 0; i < 8; i++) begin
      t.rem = {t.rem[62:0], 1'b0};
      if (t.rem >= den) begin
        t.rem = t.rem - den;
        t.q   = {t.q[15:0], 1'b1};
      end else begin
        t.q   = {t.q[15:0], 1'b0};
      end
    end
    return t;
  endfunction

endpackage

/* sv/hvd_front.sv */
// Front stages: transforms, hook image, squared distance and factor select
`timescale 1ns / 1ps
module hvd_front import hvd_pkg::*; (
  input  logic                    clk,
  input  logic [FRONT_STAGES-1:0] en,
  input  in_t                     din,
  input  cfg_t                    cfg,
  input  logic [61:0]             r_sq,
  input  logic [31:0]             coef [COEF_DEPTH],
  output carry_t                  carry,
  output logic [63:0]             len_sq,
  output fac_sel_t                sel
);

  logic signed [31:0] co_a [3];
  logic signed [31:0] cen [3];
  logic [16:0]        w_in;

  carry_t             c0, c1, c1_next, c2, c3;
  logic signed [63:0] up0 [9];
  logic signed [63:0] hp0 [9];
  logic signed [31:0] p1 [3];
  logic signed [31:0] p_next [3];
  logic signed [31:0] img_next [3];
  logic [31:0]        m2 [3];
  logic [31:0]        m_next [3];
  logic [63:0]        sq3 [3];
  logic [65:0]        len_sum;
  logic [63:0]        len_sat;
  fac_sel_t           sel_next;

  assign co_a[0] = din.vertex_x;
  assign co_a[1] = din.vertex_y;
  assign co_a[2] = din.vertex_z;
  assign cen[0]  = cfg.center_x;
  assign cen[1]  = cfg.center_y;
  assign cen[2]  = cfg.center_z;

  // Clamp the weight to one and invert on request
  always_comb begin
    w_in = (din.vertex_weight > ONE_Q16) ? ONE_Q16 : din.vertex_weight;
    if (cfg.mode_flags[1]) w_in = ONE_Q16 - w_in;
  end

  // Stage 0: all matrix products
  always_ff @(posedge clk) begin
    if (en[0]) begin
      c0.co    <= {din.vertex_z, din.vertex_y, din.vertex_x};
      c0.img   <= '0;
      c0.w     <= w_in;
      c0.has_w <= din.has_weight;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          up0[i*3+j] <= mul_s32($signed(coef[UNI_BASE+i*3+j]), co_a[j]);
          hp0[i*3+j] <= mul_s32($signed(coef[i*4+j]), co_a[j]);
        end
      end
    end
  end

  // Stage 1: sum floored terms and saturate
  always_comb begin
    c1_next = c0;
    for (int i = 0; i < 3; i++) begin
      if (cfg.mode_flags[0]) begin
        p_next[i] = sat32(66'(up0[i*3] >>> 16) + 66'(up0[i*3+1] >>> 16)
                          + 66'(up0[i*3+2] >>> 16));
      end else begin
        p_next[i] = $signed(c0.co[i]);
      end
      img_next[i] = sat32(66'($signed(coef[i*4+3])) + 66'(hp0[i*3] >>> 16)
                          + 66'(hp0[i*3+1] >>> 16) + 66'(hp0[i*3+2] >>> 16));
      c1_next.img[i] = img_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      c1 <= c1_next;
      for (int i = 0; i < 3; i++) p1[i] <= p_next[i];
    end
  end

  // Stage 2: distance magnitude per axis
  always_comb begin
    logic signed [32:0] d;
    for (int i = 0; i < 3; i++) begin
      d         = 33'(cen[i]) - 33'(p1[i]);
      m_next[i] = d[32] ? 32'(-d) : 32'(d);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      c2 <= c1;
      for (int i = 0; i < 3; i++) m2[i] <= m_next[i];
    end
  end

  // Stage 3: squares
  always_ff @(posedge clk) begin
    if (en[3]) begin
      c3 <= c2;
      for (int i = 0; i < 3; i++) sq3[i] <= 64'(m2[i]) * 64'(m2[i]);
    end
  end

  // Stage 4: saturating length and the factor source
  always_comb begin
    len_sum = 66'(sq3[0]) + 66'(sq3[1]) + 66'(sq3[2]);
    len_sat = (len_sum[65:64] != 2'b00) ? '1 : len_sum[63:0];
    if (cfg.falloff_kind == KIND_NONE || cfg.hook_radius == '0) begin
      sel_next = FAC_STRENGTH;
    end else if (len_sat > 64'(r_sq)) begin
      sel_next = FAC_ZERO;
    end else if (len_sat == '0 || cfg.falloff_kind == KIND_CONSTANT) begin
      sel_next = FAC_STRENGTH;
    end else begin
      sel_next = FAC_CURVE;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      carry  <= c3;
      len_sq <= len_sat;
      sel    <= sel_next;
    end
  end

endmodule

/* sv/hvd_falloff.sv */
// Falloff stages: square roots, ratio division, curve shaping and scaling
`timescale 1ns / 1ps
module hvd_falloff import hvd_pkg::*; (
  input  logic                   clk,
  input  logic [FALL_STAGES-1:0] en,
  input  carry_t                 carry_i,
  input  logic [63:0]            len_sq_i,
  input  fac_sel_t               sel_i,
  input  cfg_t                   cfg,
  input  logic [61:0]            r_sq,
  output carry_t                 carry_o,
  output logic [16:0]            fac_o
);

  carry_t      ca [FALL_STAGES];
  fac_sel_t    sa [FALL_STAGES];
  logic [63:0] la [4];
  sq_t         qa [4];

  logic [31:0] dist_cl;
  dv_t         dv4, dv5, dv6, dv5_next;
  logic [63:0] den4, den5;
  logic [16:0] f7;
  logic [33:0] ff7, sph7;
  logic [17:0] g7;
  logic [16:0] f8, sh8, sm8;
  sq_t         qb8, qb9, qb10, qb11;
  logic [16:0] f_b [9:11];
  logic [16:0] sh_b [9:11];
  logic [16:0] sm_b [9:11];
  logic [16:0] s_cl;
  logic [16:0] fc;
  logic [33:0] prod12;
  logic [16:0] fac_sel;
  logic [16:0] fac_next;

  assign s_cl = (cfg.strength > ONE_Q16) ? ONE_Q16 : cfg.strength;

  // Carry vertex data and factor source along
  always_ff @(posedge clk) begin
    if (en[0]) begin
      ca[0] <= carry_i;
      sa[0] <= sel_i;
    end
    for (int k = 1; k < FALL_STAGES; k++) begin
      if (en[k]) begin
        ca[k] <= ca[k-1];
        sa[k] <= sa[k-1];
      end
    end
  end

  // Stages 0-3: square root of the length, eight digits a stage
  always_ff @(posedge clk) begin
    if (en[0]) begin
      la[0] <= len_sq_i;
      qa[0] <= sqrt_steps('{x: len_sq_i, rem: '0, root: '0}, 8);
    end
    for (int k = 1; k < 4; k++) begin
      if (en[k]) begin
        la[k] <= la[k-1];
        qa[k] <= sqrt_steps(qa[k-1], 8);
      end
    end
  end

  // Stage 4: numerator and denominator of the ratio
  assign dist_cl = (qa[3].root > 32'(cfg.hook_radius)) ? 32'(cfg.hook_radius)
                                                       : qa[3].root;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      dv4.q <= '0;
      if (cfg.falloff_kind == KIND_INVSQ) begin
        dv4.rem <= 64'(r_sq) - la[3];
        den4    <= 64'(r_sq);
      end else begin
        dv4.rem <= 64'(32'(cfg.hook_radius) - dist_cl);
        den4    <= 64'(cfg.hook_radius);
      end
    end
  end

  // Stages 5-6: integer bit, then sixteen fraction bits
  always_comb begin
    dv5_next = dv4;
    if (dv4.rem >= den4) begin
      dv5_next.rem = dv4.rem - den4;
      dv5_next.q   = 17'd1;
    end
    dv5_next = div_steps(dv5_next, den4);
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      dv5  <= dv5_next;
      den5 <= den4;
    end
    if (en[6]) dv6 <= div_steps(dv5, den5);
  end

  // Stage 7: curve products
  always_ff @(posedge clk) begin
    if (en[7]) begin
      f7   <= dv6.q;
      ff7  <= 34'(dv6.q) * 34'(dv6.q);
      g7   <= 18'd196608 - 18'({dv6.q, 1'b0});
      sph7 <= 34'(dv6.q) * 34'(18'd131072 - 18'(dv6.q));
    end
  end

  // Stage 8: sharp and smooth products and the second root's operand
  always_ff @(posedge clk) begin
    if (en[8]) begin
      f8    <= f7;
      sh8   <= 17'(ff7 >> 16);
      sm8   <= 17'((52'(ff7) * 52'(g7)) >> 32);
      qb8.rem  <= '0;
      qb8.root <= '0;
      if (cfg.falloff_kind == KIND_ROOT) qb8.x <= 64'({f7, 16'b0}) << 30;
      else                               qb8.x <= 64'(sph7) << 30;
    end
  end

  // Stages 9-11: seventeen-digit root
  always_ff @(posedge clk) begin
    if (en[9]) begin
      qb9     <= sqrt_steps(qb8, 6);
      f_b[9]  <= f8;
      sh_b[9] <= sh8;
      sm_b[9] <= sm8;
    end
    if (en[10]) begin
      qb10     <= sqrt_steps(qb9, 6);
      f_b[10]  <= f_b[9];
      sh_b[10] <= sh_b[9];
      sm_b[10] <= sm_b[9];
    end
    if (en[11]) begin
      qb11     <= sqrt_steps(qb10, 5);
      f_b[11]  <= f_b[10];
      sh_b[11] <= sh_b[10];
      sm_b[11] <= sm_b[10];
    end
  end

  // Stage 12: pick the shaped curve and scale by strength
  always_comb begin
    case (cfg.falloff_kind)
      KIND_SHARP:             fc = sh_b[11];
      KIND_SMOOTH:            fc = sm_b[11];
      KIND_ROOT, KIND_SPHERE: fc = qb11.root[16:0];
      default:                fc = f_b[11];
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[12]) prod12 <= 34'(fc) * 34'(s_cl);
  end

  // Stage 13: final factor, then the vertex weight
  always_comb begin
    case (sa[12])
      FAC_STRENGTH: fac_sel = s_cl;
      FAC_ZERO:     fac_sel = '0;
      default:      fac_sel = 17'(prod12 >> 16);
    endcase
    if (ca[12].has_w) fac_next = 17'((34'(fac_sel) * 34'(ca[12].w)) >> 16);
    else              fac_next = fac_sel;
  end

  always_ff @(posedge clk) begin
    if (en[13]) fac_o <= fac_next;
  end

  assign carry_o = ca[FALL_STAGES-1];

endmodule

/* sv/hook_vertex_deform_falloff_core.sv */
// A deform transfer passes the front, falloff and blend stages before reaching the output.
// Throughput: one vertex per cycle; each stage moves on whenever the next one frees.
// Coefficient writes take one input transfer, give no result and hold no stage.
// Synchronous reset sets the strength to one and clears the rest of the configuration,
// the coefficient store and all stage valid bits; the block accepts items in the first cycle after reset.
`timescale 1ns / 1ps
module hook_vertex_deform_falloff_core import hvd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  `include "hook_vertex_deform_falloff_core_assert.svh"

  cfg_t               cfg;
  logic [61:0]        r_sq;
  logic [31:0]        coef [COEF_DEPTH];
  logic [STAGES-1:0]  v;
  logic [STAGES:0]    ready;
  logic               in_xfer;
  logic               coef_wr;

  carry_t             front_carry, fall_carry;
  logic [63:0]        front_len;
  fac_sel_t           front_sel;
  logic [16:0]        fac;
  logic [31:0]        co_b0 [3];
  logic signed [50:0] prod_b0 [3];

  // Stage handshake: a stage loads when empty or when its content moves on
  always_comb begin
    ready[STAGES] = !out_stall;
    for (int k = STAGES - 1; k >= 0; k--) ready[k] = !v[k] || ready[k+1];
  end

  assign in_stall  = !ready[0];
  assign in_xfer   = in_valid && ready[0];
  assign coef_wr   = in_xfer && (in_data.opcode == OP_WRITE)
                     && (in_data.coef_index < 5'(COEF_DEPTH));
  assign out_valid = v[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ready[0]) v[0] <= in_valid && (in_data.opcode == OP_DEFORM);
      for (int k = 1; k < STAGES; k++) begin
        if (ready[k]) v[k] <= v[k-1];
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.falloff_kind <= KIND_NONE;
      cfg.hook_radius  <= '0;
      cfg.strength     <= ONE_Q16;
      cfg.mode_flags   <= '0;
      cfg.center_x     <= '0;
      cfg.center_y     <= '0;
      cfg.center_z     <= '0;
      r_sq             <= '0;
    end else begin
      r_sq <= 62'(cfg.hook_radius) * 62'(cfg.hook_radius);
      if (cfg_wen) begin
        case (cfg_addr)
          REG_KIND:     cfg.falloff_kind <= cfg_wdata[2:0];
          REG_RADIUS:   cfg.hook_radius  <= cfg_wdata[30:0];
          REG_STRENGTH: cfg.strength     <= cfg_wdata[16:0];
          REG_FLAGS:    cfg.mode_flags   <= cfg_wdata[1:0];
          REG_CX:       cfg.center_x     <= cfg_wdata;
          REG_CY:       cfg.center_y     <= cfg_wdata;
          REG_CZ:       cfg.center_z     <= cfg_wdata;
          default:      ;
        endcase
      end
    end
  end

  // Coefficient store; a vertex reads it only while entering the first two stages
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < COEF_DEPTH; i++) coef[i] <= '0;
    end else if (coef_wr) begin
      coef[in_data.coef_index] <= in_data.coef_value;
    end
  end

  hvd_front u_front (
    .clk    (clk),
    .en     (ready[FRONT_STAGES-1:0]),
    .din    (in_data),
    .cfg    (cfg),
    .r_sq   (r_sq),
    .coef   (coef),
    .carry  (front_carry),
    .len_sq (front_len),
    .sel    (front_sel)
  );

  hvd_falloff u_falloff (
    .clk      (clk),
    .en       (ready[FRONT_STAGES+FALL_STAGES-1:FRONT_STAGES]),
    .carry_i  (front_carry),
    .len_sq_i (front_len),
    .sel_i    (front_sel),
    .cfg      (cfg),
    .r_sq     (r_sq),
    .carry_o  (fall_carry),
    .fac_o    (fac)
  );

  // Blend stage 0: offset toward the image times the factor
  always_ff @(posedge clk) begin
    logic signed [32:0] diff;
    if (ready[STAGES-2]) begin
      for (int i = 0; i < 3; i++) begin
        diff       = 33'($signed(fall_carry.img[i])) - 33'($signed(fall_carry.co[i]));
        co_b0[i]   <= fall_carry.co[i];
        prod_b0[i] <= 51'(diff) * 51'($signed({1'b0, fac}));
      end
    end
  end

  // Blend stage 1: add back and saturate into the output register
  always_ff @(posedge clk) begin
    if (ready[STAGES-1]) begin
      out_data.out_x <= sat32(66'($signed(co_b0[0])) + 66'(prod_b0[0] >>> 16));
      out_data.out_y <= sat32(66'($signed(co_b0[1])) + 66'(prod_b0[1] >>> 16));
      out_data.out_z <= sat32(66'($signed(co_b0[2])) + 66'(prod_b0[2] >>> 16));
    end
  end

  `HVD_ASSERT_NEXT(a_coef_write, coef_wr, coef[$past(in_data.coef_index)] == $past(in_data.coef_value))
  `HVD_ASSERT_NEXT(a_deform_enters, in_xfer && (in_data.opcode == OP_DEFORM), v[0])
  `HVD_ASSERT_NEXT(a_mid_hold, v[10] && !ready[11], v[10])
  `HVD_ASSERT_NEXT(a_drain, out_valid && !out_stall && !v[STAGES-2], !out_valid)

endmodule
